// ===== rtl/hdc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the holiday date calculator.
// Used by every module of the block; depends on nothing.

package hdc_pkg;

  localparam int NumHolidays = 17;
  // Register stages from the input transfer to the output register.
  localparam int NumStages = 6;

  // Holiday codes.
  localparam logic [4:0] HOL_NEW_YEAR     = 5'd0;
  localparam logic [4:0] HOL_XMAS_EVE     = 5'd1;
  localparam logic [4:0] HOL_NEW_YEAR_EVE = 5'd2;
  localparam logic [4:0] HOL_MLK          = 5'd3;
  localparam logic [4:0] HOL_PRESIDENTS   = 5'd4;
  localparam logic [4:0] HOL_VALENTINE    = 5'd5;
  localparam logic [4:0] HOL_HALLOWEEN    = 5'd6;
  localparam logic [4:0] HOL_ST_PATRICK   = 5'd7;
  localparam logic [4:0] HOL_APRIL_FOOLS  = 5'd8;
  localparam logic [4:0] HOL_MOTHERS      = 5'd9;
  localparam logic [4:0] HOL_FATHERS      = 5'd10;
  localparam logic [4:0] HOL_LABOUR       = 5'd11;
  localparam logic [4:0] HOL_MEMORIAL     = 5'd12;
  localparam logic [4:0] HOL_INDEPENDENCE = 5'd13;
  localparam logic [4:0] HOL_THANKSGIVING = 5'd14;
  localparam logic [4:0] HOL_XMAS         = 5'd15;
  localparam logic [4:0] HOL_EASTER       = 5'd16;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_NTH,
    KIND_LAST,
    KIND_EASTER
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [1:0] weeks;
  } rule_t;

  // Result of the rule path, as handed to the output stage.
  typedef struct packed {
    logic       known;
    logic       easter;
    logic [3:0] month;
    logic [4:0] day;
  } rule_res_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

  function automatic rule_t rule_lookup(input logic [4:0] id);
    rule_t r;
    r = '{kind: KIND_FIXED, month: 4'd0, day: 5'd0, weekday: 3'd0, weeks: 2'd0};
    unique case (id)
      HOL_NEW_YEAR:     r = '{KIND_FIXED,  4'd1,  5'd1,  3'd0, 2'd0};
      HOL_XMAS_EVE:     r = '{KIND_FIXED,  4'd12, 5'd24, 3'd0, 2'd0};
      HOL_NEW_YEAR_EVE: r = '{KIND_FIXED,  4'd12, 5'd31, 3'd0, 2'd0};
      HOL_MLK:          r = '{KIND_NTH,    4'd1,  5'd1,  3'd1, 2'd2};
      HOL_PRESIDENTS:   r = '{KIND_NTH,    4'd2,  5'd1,  3'd1, 2'd2};
      HOL_VALENTINE:    r = '{KIND_FIXED,  4'd2,  5'd14, 3'd0, 2'd0};
      HOL_HALLOWEEN:    r = '{KIND_FIXED,  4'd10, 5'd31, 3'd0, 2'd0};
      HOL_ST_PATRICK:   r = '{KIND_FIXED,  4'd3,  5'd17, 3'd0, 2'd0};
      HOL_APRIL_FOOLS:  r = '{KIND_FIXED,  4'd4,  5'd1,  3'd0, 2'd0};
      HOL_MOTHERS:      r = '{KIND_NTH,    4'd5,  5'd1,  3'd0, 2'd1};
      HOL_FATHERS:      r = '{KIND_NTH,    4'd6,  5'd1,  3'd0, 2'd2};
      HOL_LABOUR:       r = '{KIND_NTH,    4'd9,  5'd1,  3'd1, 2'd0};
      HOL_MEMORIAL:     r = '{KIND_LAST,   4'd5,  5'd31, 3'd1, 2'd0};
      HOL_INDEPENDENCE: r = '{KIND_FIXED,  4'd7,  5'd4,  3'd0, 2'd0};
      HOL_THANKSGIVING: r = '{KIND_NTH,    4'd11, 5'd1,  3'd4, 2'd3};
      HOL_XMAS:         r = '{KIND_FIXED,  4'd12, 5'd25, 3'd0, 2'd0};
      HOL_EASTER:       r = '{KIND_EASTER, 4'd0,  5'd0,  3'd0, 2'd0};
      default:          r = '{KIND_FIXED,  4'd0,  5'd0,  3'd0, 2'd0};
    endcase
    return r;
  endfunction

  // Weekday offset of the first of each month in the shifted-year scheme.
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] o;
    o = 3'd0;
    unique case (month)
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // Remainder by seven through a reciprocal; exact for x below 13107.
  function automatic logic [2:0] mod7(input logic [13:0] x);
    logic [29:0] prod;
    logic [13:0] quo;
    logic [13:0] rem;
    prod = {16'd0, x} * 30'd9363;
    quo  = prod[29:16];
    rem  = x - 14'(quo * 14'd7);
    return rem[2:0];
  endfunction

  // Quotient by one hundred through a reciprocal; exact for any 13-bit x.
  function automatic logic [6:0] div100(input logic [12:0] x);
    logic [25:0] prod;
    prod = {13'd0, x} * 26'd5243;
    return prod[25:19];
  endfunction

endpackage

// ===== rtl/hdc_wday.sv =====
// Rule path: table lookup, weekday of the anchor date and the resulting day.
// Five register stages; depends on hdc_pkg.

module hdc_wday (
  input  logic                  clk_i,
  input  logic [4:0]            en_i,
  input  logic [4:0]            holiday_id_i,
  input  logic [11:0]           year_i,
  output hdc_pkg::rule_res_t    res_o
);
  import hdc_pkg::*;

  rule_t       rule1_d, rule1_q, rule2_q, rule3_q;
  logic        known1_d, known1_q, known2_q, known3_q;
  logic [12:0] wy1_d, wy1_q;
  logic [6:0]  y100_1_d, y100_1_q;
  logic [13:0] wsum2_d, wsum2_q;
  logic [2:0]  wd3_d, wd3_q;
  logic [3:0]  fwd_raw, back_raw;
  logic [2:0]  fwd, back;
  rule_res_t   res4_d, res4_q, res5_q;

  // Stage 1: rule lookup and the century quotient of the shifted year.
  always_comb begin
    rule1_d  = rule_lookup(holiday_id_i);
    known1_d = (holiday_id_i < 5'(NumHolidays));
    wy1_d    = 13'(year_i) + 13'd400 - ((rule1_d.month < 4'd3) ? 13'd1 : 13'd0);
    y100_1_d = div100(wy1_d);
  end

  // Stage 2: the weekday sum before reduction.
  assign wsum2_d = 14'(wy1_q) + 14'(wy1_q >> 2) - 14'(y100_1_q) + 14'(y100_1_q >> 2)
                 + 14'(month_offset(rule1_q.month)) + 14'(rule1_q.day);

  // Stage 3: reduction to a weekday, 0 for Sunday.
  assign wd3_d = mod7(wsum2_q);

  // Stage 4: step forward to the wanted weekday, or back for the last one.
  always_comb begin
    fwd_raw  = {1'b0, rule3_q.weekday} + 4'd7 - {1'b0, wd3_q};
    back_raw = {1'b0, wd3_q} + 4'd7 - {1'b0, rule3_q.weekday};
    fwd      = (fwd_raw >= 4'd7) ? 3'(fwd_raw - 4'd7) : fwd_raw[2:0];
    back     = (back_raw >= 4'd7) ? 3'(back_raw - 4'd7) : back_raw[2:0];
    res4_d.known  = known3_q;
    res4_d.easter = known3_q && (rule3_q.kind == KIND_EASTER);
    res4_d.month  = rule3_q.month;
    res4_d.day    = rule3_q.day;
    unique case (rule3_q.kind)
      KIND_FIXED:  res4_d.day = rule3_q.day;
      KIND_NTH:    res4_d.day = rule3_q.day + 5'(fwd) + 5'(rule3_q.weeks) * 5'd7;
      KIND_LAST:   res4_d.day = rule3_q.day - 5'(back);
      KIND_EASTER: res4_d.day = 5'd0;
      default:     res4_d.day = 5'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rule1_q  <= rule1_d;
      known1_q <= known1_d;
      wy1_q    <= wy1_d;
      y100_1_q <= y100_1_d;
    end
    if (en_i[1]) begin
      rule2_q  <= rule1_q;
      known2_q <= known1_q;
      wsum2_q  <= wsum2_d;
    end
    if (en_i[2]) begin
      rule3_q  <= rule2_q;
      known3_q <= known2_q;
      wd3_q    <= wd3_d;
    end
    if (en_i[3]) begin
      res4_q <= res4_d;
    end
    if (en_i[4]) begin
      res5_q <= res4_q;
    end
  end

  assign res_o = res5_q;

endmodule

// ===== rtl/hdc_easter.sv =====
// Easter path: the anonymous Gregorian computus spread over five register stages.
// Constant divisions are reciprocal multiplies or shifts, and the one by 451 a compare; depends on hdc_pkg.

module hdc_easter (
  input  logic              clk_i,
  input  logic [4:0]        en_i,
  input  logic [11:0]       year_i,
  output hdc_pkg::date_t    date_o
);
  import hdc_pkg::*;

  // Stage 1 registers.
  logic [11:0] year1_q;
  logic [7:0]  q19_1_d, q19_1_q;
  logic [5:0]  b1_d, b1_q;
  logic [23:0] p19;
  logic [24:0] p100;
  // Stage 2 registers.
  logic [4:0]  a2_d, a2_q;
  logic [5:0]  b2_q;
  logic [6:0]  c2_d, c2_q;
  logic [3:0]  d2_q;
  logic [1:0]  e2_q;
  logic [1:0]  f2_d, f2_q;
  logic [10:0] pf;
  logic [11:0] a2_full, c2_full;
  // Stage 3 registers.
  logic [4:0]  a3_q;
  logic [5:0]  b3_q;
  logic [6:0]  c3_q;
  logic [3:0]  d3_q;
  logic [1:0]  e3_q;
  logic [3:0]  g3_d, g3_q;
  logic [11:0] pg;
  // Stage 4 registers.
  logic [8:0]  hsum;
  logic [18:0] ph;
  logic [8:0]  hrem;
  logic [4:0]  h4_d, h4_q;
  logic [4:0]  a4_q;
  logic [1:0]  e4_q;
  logic [4:0]  i4_q;
  logic [1:0]  k4_q;
  // Stage 5 registers.
  logic [6:0]  lsum;
  logic [2:0]  l5_d, l5_q;
  logic [4:0]  h5_q;
  logic [4:0]  a5_q;
  // Output logic.
  logic [8:0]  msum;
  logic [7:0]  s;

  // Stage 1: quotients of the year by nineteen and by one hundred.
  always_comb begin
    p19     = {12'd0, year_i} * 24'd3450;
    p100    = {13'd0, year_i} * 25'd5243;
    q19_1_d = p19[23:16];
    b1_d    = p100[24:19];
  end

  // Stage 2: remainders, century terms and the correction f.
  always_comb begin
    a2_full = year1_q - 12'(q19_1_q) * 12'd19;
    c2_full = year1_q - 12'(b1_q) * 12'd100;
    a2_d    = a2_full[4:0];
    c2_d    = c2_full[6:0];
    pf      = 11'(b1_q + 6'd8) * 11'd41;
    f2_d    = pf[10:10] == 1'b1 ? 2'd1 : 2'd0;
  end

  // Stage 3: g = (b - f + 1) / 3.
  always_comb begin
    pg   = 12'(b2_q - 6'(f2_q) + 6'd1) * 12'd86;
    g3_d = pg[11:8];
  end

  // Stage 4: h = (19a + b + 15 - d - g) mod 30.
  always_comb begin
    hsum = 9'(a3_q) * 9'd19 + 9'(b3_q) + 9'd15 - 9'(d3_q) - 9'(g3_q);
    ph   = {10'd0, hsum} * 19'd547;
    hrem = hsum - 9'(ph[18:14]) * 9'd30;
    h4_d = hrem[4:0];
  end

  // Stage 5: l = (32 + 2e + 2i - h - k) mod 7.
  always_comb begin
    lsum = 7'd32 + {4'd0, e4_q, 1'b0} + {1'b0, i4_q, 1'b0} - 7'(h4_q) - 7'(k4_q);
    l5_d = mod7(14'(lsum));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      year1_q <= year_i;
      q19_1_q <= q19_1_d;
      b1_q    <= b1_d;
    end
    if (en_i[1]) begin
      a2_q <= a2_d;
      b2_q <= b1_q;
      c2_q <= c2_d;
      d2_q <= 4'(b1_q >> 2);
      e2_q <= b1_q[1:0];
      f2_q <= f2_d;
    end
    if (en_i[2]) begin
      a3_q <= a2_q;
      b3_q <= b2_q;
      c3_q <= c2_q;
      d3_q <= d2_q;
      e3_q <= e2_q;
      g3_q <= g3_d;
    end
    if (en_i[3]) begin
      h4_q <= h4_d;
      a4_q <= a3_q;
      e4_q <= e3_q;
      i4_q <= c3_q[6:2];
      k4_q <= c3_q[1:0];
    end
    if (en_i[4]) begin
      l5_q <= l5_d;
      h5_q <= h4_q;
      a5_q <= a4_q;
    end
  end

  // The sum never reaches twice 451, so m is a single compare, and s lies in 107..149,
  // which leaves only March or April.
  always_comb begin
    msum = 9'(a5_q) + 9'(h5_q) * 9'd11 + 9'(l5_q) * 9'd22;
    s    = 8'(h5_q) + 8'(l5_q) + 8'd114 - ((msum >= 9'd451) ? 8'd7 : 8'd0);
    if (s >= 8'd124) begin
      date_o.month = 4'd4;
      date_o.day   = 5'(s - 8'd123);
    end else begin
      date_o.month = 4'd3;
      date_o.day   = 5'(s - 8'd92);
    end
  end

endmodule

// ===== rtl/holiday_date_calculator_top.sv =====
// Top level of the holiday date calculator: stage valid bits, stall control and output register.
// Instantiates hdc_wday and hdc_easter; depends on hdc_pkg.
//
//   Channel | Direction | Handshake                | Payload
//   in      | input     | in_valid_i / in_ready_o  | holiday_id_i, year_i
//   out     | output    | out_valid_o / out_ready_i| month_o, day_o, valid_res_o
//
// One transfer is accepted every cycle while in_ready_o is high; out_valid_o rises once the item has
// reached the output register, a depth set by the Easter chain of dependent constant reductions.
// Reset clears only the stage valid bits; the data registers need none.
// A stage takes new data when it is empty or when the stage after it moves on. The enables
// form a combinational chain, so a stall at the output holds every full stage at once, and
// in_ready_o falls only when all six stages are full and the output is stalled.

module holiday_date_calculator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  holiday_id_i,
  input  logic [11:0] year_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic        valid_res_o
);
  import hdc_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] stage_en;
  rule_res_t            rule_res;
  date_t                easter_date;
  logic [3:0]           month_d, month_q;
  logic [4:0]           day_d, day_q;
  logic                 known_q;

  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  hdc_wday u_wday (
    .clk_i        (clk_i),
    .en_i         (stage_en[NumStages-2:0]),
    .holiday_id_i (holiday_id_i),
    .year_i       (year_i),
    .res_o        (rule_res)
  );

  hdc_easter u_easter (
    .clk_i  (clk_i),
    .en_i   (stage_en[NumStages-2:0]),
    .year_i (year_i),
    .date_o (easter_date)
  );

  always_comb begin
    if (rule_res.easter) begin
      month_d = easter_date.month;
      day_d   = easter_date.day;
    end else begin
      month_d = rule_res.month;
      day_d   = rule_res.day;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[NumStages-1]) begin
      month_q <= month_d;
      day_q   <= day_d;
      known_q <= rule_res.known;
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign month_o     = month_q;
  assign day_o       = day_q;
  assign valid_res_o = known_q;

endmodule

// ===== rtl/hdc_checker.sv =====
// Port-level checker for the holiday date calculator, bound to the top level.
// Depends on hdc_pkg and holiday_date_calculator_top.

module hdc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [4:0]  holiday_id_i,
  input  logic [11:0] year_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [3:0]  month_o,
  input  logic [4:0]  day_o,
  input  logic        valid_res_o
);
  import hdc_pkg::*;

  logic [3:0] cnt_d, cnt_q;
  logic       in_xfer, out_xfer;

  assign in_xfer        = in_valid_i && in_ready_o;
  assign out_xfer       = out_valid_o && out_ready_i;
  assign cnt_d          = cnt_q + 4'(in_xfer) - 4'(out_xfer);

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(NumStages))
    else $error("more items in flight than pipeline stages");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != 4'd0))
    else $error("result offered with no item in flight");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(holiday_id_i) && $stable(year_i)))
    else $error("waiting request changed before its transfer");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (month_o == 4'd0 && day_o == 5'd0))
    else $error("unrecognised code gave a nonzero date");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(month_o) && $stable(day_o) && $stable(valid_res_o)))
    else $error("stalled result changed");

endmodule

bind holiday_date_calculator_top hdc_checker u_hdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .holiday_id_i (holiday_id_i),
  .year_i       (year_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .month_o      (month_o),
  .day_o        (day_o),
  .valid_res_o  (valid_res_o)
);

// ===== tb/sv/holiday_date_checker.sv =====
`timescale 1ns / 1ps
// Checker for the holiday date calculator: watches both channels, predicts each date and
// compares it with the block's result. Depends on hdc_pkg for the holiday codes.

module holiday_date_checker
  import hdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [4:0]  holiday_id_i,
  input  logic [11:0] year_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic        valid_res_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int SUNDAY   = 0;
  localparam int MONDAY   = 1;
  localparam int THURSDAY = 4;

  typedef struct {
    logic [3:0] month;
    logic [4:0] day;
    logic       known;
  } holiday_date_t;

  holiday_date_t expected_dates[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  // Weekday (Sunday is zero) of a date; the year is moved on by 400 so that nothing goes
  // negative, and January and February count as the end of the year before.
  function automatic int weekday_on(input int yr, input int mon, input int dom);
    int y;
    int first_off;
    y = yr + 400;
    if (mon < 3) begin
      y = y - 1;
    end
    case (mon)
      2, 6:    first_off = 3;
      3, 11:   first_off = 2;
      4, 7:    first_off = 5;
      8:       first_off = 1;
      9, 12:   first_off = 4;
      10:      first_off = 6;
      default: first_off = 0;
    endcase
    return (y + y / 4 - y / 100 + y / 400 + first_off + dom) % 7;
  endfunction

  function automatic int nth_weekday(input int yr, input int mon, input int wd,
                                     input int extra_weeks);
    return 1 + (wd + 7 - weekday_on(yr, mon, 1)) % 7 + 7 * extra_weeks;
  endfunction

  function automatic int last_weekday(input int yr, input int mon, input int last_dom,
                                      input int wd);
    return last_dom - (weekday_on(yr, mon, last_dom) + 7 - wd) % 7;
  endfunction

  // Anonymous Gregorian computus; the result is packed as month * 32 + day.
  function automatic int easter_on(input int yr);
    int golden, century, yy, leap_c, rem_c, corr, moon_c, epact, leap_y, rem_y;
    int wk, shift, sum;
    golden  = yr % 19;
    century = yr / 100;
    yy      = yr % 100;
    leap_c  = century / 4;
    rem_c   = century % 4;
    corr    = (century + 8) / 25;
    moon_c  = (century - corr + 1) / 3;
    epact   = (19 * golden + century + 15 - leap_c - moon_c) % 30;
    leap_y  = yy / 4;
    rem_y   = yy % 4;
    wk      = (32 + 2 * rem_c + 2 * leap_y - epact - rem_y) % 7;
    shift   = (golden + 11 * epact + 22 * wk) / 451;
    sum     = epact + wk + 114 - 7 * shift;
    return (sum / 31) * 32 + (sum % 31 + 1);
  endfunction

  function automatic holiday_date_t holiday_date_of(input logic [4:0] id,
                                                    input logic [11:0] yr_bits);
    holiday_date_t r;
    int yr;
    int packed_date;
    yr      = int'(yr_bits);
    r.known = 1'b1;
    r.month = 4'd0;
    r.day   = 5'd0;
    case (id)
      HOL_NEW_YEAR:     begin r.month = 4'd1;  r.day = 5'd1;  end
      HOL_XMAS_EVE:     begin r.month = 4'd12; r.day = 5'd24; end
      HOL_NEW_YEAR_EVE: begin r.month = 4'd12; r.day = 5'd31; end
      HOL_VALENTINE:    begin r.month = 4'd2;  r.day = 5'd14; end
      HOL_HALLOWEEN:    begin r.month = 4'd10; r.day = 5'd31; end
      HOL_ST_PATRICK:   begin r.month = 4'd3;  r.day = 5'd17; end
      HOL_APRIL_FOOLS:  begin r.month = 4'd4;  r.day = 5'd1;  end
      HOL_INDEPENDENCE: begin r.month = 4'd7;  r.day = 5'd4;  end
      HOL_XMAS:         begin r.month = 4'd12; r.day = 5'd25; end
      HOL_MLK: begin
        r.month = 4'd1;
        r.day   = 5'(nth_weekday(yr, 1, MONDAY, 2));
      end
      HOL_PRESIDENTS: begin
        r.month = 4'd2;
        r.day   = 5'(nth_weekday(yr, 2, MONDAY, 2));
      end
      HOL_MOTHERS: begin
        r.month = 4'd5;
        r.day   = 5'(nth_weekday(yr, 5, SUNDAY, 1));
      end
      HOL_FATHERS: begin
        r.month = 4'd6;
        r.day   = 5'(nth_weekday(yr, 6, SUNDAY, 2));
      end
      HOL_LABOUR: begin
        r.month = 4'd9;
        r.day   = 5'(nth_weekday(yr, 9, MONDAY, 0));
      end
      HOL_THANKSGIVING: begin
        r.month = 4'd11;
        r.day   = 5'(nth_weekday(yr, 11, THURSDAY, 3));
      end
      HOL_MEMORIAL: begin
        r.month = 4'd5;
        r.day   = 5'(last_weekday(yr, 5, 31, MONDAY));
      end
      HOL_EASTER: begin
        packed_date = easter_on(yr);
        r.month     = 4'(packed_date / 32);
        r.day       = 5'(packed_date % 32);
      end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    holiday_date_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_dates.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: month %0d day %0d flag %0b",
                               month_i, day_i, valid_res_i));
        end else begin
          want = expected_dates.pop_front();
          if (month_i !== want.month)
            flag_error($sformatf("month %0d, predicted %0d", month_i, want.month));
          if (day_i !== want.day)
            flag_error($sformatf("day %0d, predicted %0d", day_i, want.day));
          if (valid_res_i !== want.known)
            flag_error($sformatf("recognised flag %0b, predicted %0b",
                                 valid_res_i, want.known));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_dates.push_back(holiday_date_of(holiday_id_i, year_i));
      end
      pending_o = expected_dates.size();
    end
  end

endmodule

// ===== tb/sv/tb_holiday_date_calculator_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the holiday date calculator: clock, reset, request stimulus and verdict.
// Depends on hdc_pkg, holiday_date_calculator_top and holiday_date_checker.

module tb_holiday_date_calculator_top;
  import hdc_pkg::*;

  localparam int RandomRequests = 1800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  holiday_id = 5'd0;
  logic [11:0] year = 12'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  month;
  logic [4:0]  day;
  logic        valid_res;

  int errors;
  int pending;
  int checked;
  int requests = 0;
  int known_requests = 0;
  bit steady = 1'b0;

  always #5 clk_i = ~clk_i;

  holiday_date_calculator_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .holiday_id_i (holiday_id),
    .year_i       (year),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .month_o      (month),
    .day_o        (day),
    .valid_res_o  (valid_res)
  );

  holiday_date_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .holiday_id_i (holiday_id),
    .year_i       (year),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .month_i      (month),
    .day_i        (day),
    .valid_res_i  (valid_res),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // The receiver holds off now and then, except while the stimulus runs a steady stretch.
  always @(negedge clk_i) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  task automatic send_request(input logic [4:0] id, input logic [11:0] yr);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    holiday_id <= id;
    year       <= yr;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    requests++;
    if (id < NumHolidays) known_requests++;
  endtask

  initial begin
    logic [4:0]  id;
    logic [11:0] yr;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every holiday but Easter at least once, with the year extremes spread over them.
    send_request(HOL_NEW_YEAR, 12'd0);
    send_request(HOL_XMAS_EVE, 12'd4095);
    send_request(HOL_NEW_YEAR_EVE, 12'd1583);
    send_request(HOL_MLK, 12'd2025);
    send_request(HOL_PRESIDENTS, 12'd0);
    send_request(HOL_VALENTINE, 12'd2047);
    send_request(HOL_HALLOWEEN, 12'd2048);
    send_request(HOL_ST_PATRICK, 12'd1);
    send_request(HOL_APRIL_FOOLS, 12'd4094);
    send_request(HOL_MOTHERS, 12'd2024);
    send_request(HOL_FATHERS, 12'd1900);
    send_request(HOL_LABOUR, 12'd2000);
    // The last Monday of May falls on the 31st itself in 2021.
    send_request(HOL_MEMORIAL, 12'd2021);
    send_request(HOL_MEMORIAL, 12'd2025);
    send_request(HOL_INDEPENDENCE, 12'd1776);
    send_request(HOL_THANKSGIVING, 12'd4095);
    send_request(HOL_XMAS, 12'd3000);
    // Easter at the year extremes and at its earliest and latest possible dates.
    send_request(HOL_EASTER, 12'd0);
    send_request(HOL_EASTER, 12'd1583);
    send_request(HOL_EASTER, 12'd4095);
    send_request(HOL_EASTER, 12'd1818);
    send_request(HOL_EASTER, 12'd2038);
    // Codes past the table must come back as unrecognised.
    send_request(5'(NumHolidays), 12'd2025);
    send_request(5'd31, 12'd4095);

    for (int n = 0; n < RandomRequests; n++) begin
      steady = (n >= 700) && (n < 1100);
      if ($urandom_range(0, 99) < 85) id = 5'($urandom_range(0, NumHolidays - 1));
      else id = 5'($urandom_range(NumHolidays, 31));
      if ($urandom_range(0, 3) == 0) yr = 12'($urandom_range(1583, 2100));
      else yr = 12'($urandom_range(0, 4095));
      send_request(id, yr);
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);

    $display("Covered %0d requests (%0d with known holiday codes) and %0d checked results,",
             requests, known_requests, checked);
    $display("with years across the whole field and random stalls on both channels.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
